>>> design/bkpt_pkg.sv
package bkpt_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF     = 16;
    localparam int PRIO_BITS_DEF   = 16;
    localparam int CAP_BITS        = 5;
    localparam int CNT_BITS        = 5;
    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd10;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_TOP    = 2'd2,
        MODE_MODIFY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_INSERT,
        S_DONE
    } t_state;

endpackage

>>> design/bkpt_scan.sv
// Sequential scan unit: folds in every slot read from the entry memory, one
// read per cycle while i_rd_en is high, and reports the top entry, the slot
// holding a given identifier and the first free slot.
module bkpt_scan #(
    parameter int MAX_ENTRIES = bkpt_pkg::MAX_ENTRIES_DEF,
    parameter int ID_BITS     = bkpt_pkg::ID_BITS_DEF,
    parameter int PRIO_BITS   = bkpt_pkg::PRIO_BITS_DEF,
    parameter int IDX_BITS    = $clog2(MAX_ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ID_BITS-1:0]   i_key,
    // read data for slot i_slot, registered by the memory
    input  logic                 i_rd_en,
    input  logic [IDX_BITS-1:0]  i_slot,
    input  logic                 i_valid,
    input  logic [ID_BITS-1:0]   i_id,
    input  logic [PRIO_BITS-1:0] i_prio,
    input  logic [IDX_BITS-1:0]  i_rank,
    output logic                 o_top_found,
    output logic [IDX_BITS-1:0]  o_top_idx,
    output logic [ID_BITS-1:0]   o_top_id,
    output logic [PRIO_BITS-1:0] o_top_prio,
    output logic [IDX_BITS-1:0]  o_top_rank,
    output logic                 o_key_found,
    output logic [IDX_BITS-1:0]  o_key_idx,
    output logic [IDX_BITS-1:0]  o_key_rank,
    output logic                 o_free_found,
    output logic [IDX_BITS-1:0]  o_free_idx
);
    logic                 r_top_found, n_top_found;
    logic [IDX_BITS-1:0]  r_top_idx, n_top_idx;
    logic [ID_BITS-1:0]   r_top_id, n_top_id;
    logic [PRIO_BITS-1:0] r_top_prio, n_top_prio;
    logic [IDX_BITS-1:0]  r_top_rank, n_top_rank;
    logic                 r_key_found, n_key_found;
    logic [IDX_BITS-1:0]  r_key_idx, n_key_idx;
    logic [IDX_BITS-1:0]  r_key_rank, n_key_rank;
    logic                 r_free_found, n_free_found;
    logic [IDX_BITS-1:0]  r_free_idx, n_free_idx;

    // Fold one slot into the running results
    always_comb begin
        n_top_found  = r_top_found;
        n_top_idx    = r_top_idx;
        n_top_id     = r_top_id;
        n_top_prio   = r_top_prio;
        n_top_rank   = r_top_rank;
        n_key_found  = r_key_found;
        n_key_idx    = r_key_idx;
        n_key_rank   = r_key_rank;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        if (i_start) begin
            n_top_found  = 1'b0;
            n_key_found  = 1'b0;
            n_free_found = 1'b0;
        end else if (i_rd_en) begin
            if (i_valid) begin
                if (!r_top_found || i_prio > r_top_prio ||
                    (i_prio == r_top_prio && i_rank < r_top_rank)) begin
                    n_top_found = 1'b1;
                    n_top_idx   = i_slot;
                    n_top_id    = i_id;
                    n_top_prio  = i_prio;
                    n_top_rank  = i_rank;
                end
                if (!r_key_found && i_id == i_key) begin
                    n_key_found = 1'b1;
                    n_key_idx   = i_slot;
                    n_key_rank  = i_rank;
                end
            end else if (!r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = i_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_found  <= 1'b0;
            r_key_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_top_found  <= n_top_found;
            r_key_found  <= n_key_found;
            r_free_found <= n_free_found;
        end
        r_top_idx  <= n_top_idx;
        r_top_id   <= n_top_id;
        r_top_prio <= n_top_prio;
        r_top_rank <= n_top_rank;
        r_key_idx  <= n_key_idx;
        r_key_rank <= n_key_rank;
        r_free_idx <= n_free_idx;
    end

    assign o_top_found  = r_top_found;
    assign o_top_idx    = r_top_idx;
    assign o_top_id     = r_top_id;
    assign o_top_prio   = r_top_prio;
    assign o_top_rank   = r_top_rank;
    assign o_key_found  = r_key_found;
    assign o_key_idx    = r_key_idx;
    assign o_key_rank   = r_key_rank;
    assign o_free_found = r_free_found;
    assign o_free_idx   = r_free_idx;

endmodule

>>> design/bounded_keyed_priority_table_core.sv
// Bounded keyed priority table.
// Input channel (i_valid/o_ready) carries one command item: push, pop, top
// or modify, with an identifier and a priority. Output channel
// (o_valid/i_ready) returns one result item per command: status, reported
// entry, eviction flag and the entry count after the command.
// Entries live in one memory with registered reads. Each command runs a
// scan pass over all MAX_ENTRIES slots (one read per cycle) to find the top
// entry, the identifier and the first free slot. A push, pop or modify that
// changes the table then runs an update pass that, after a removal,
// rewrites age ranks slot by slot (read, modify, write back), and a final
// write for an inserted or modified entry; top, a duplicate push or an
// error ends after the scan. Capacity is written on i_cfg_we; the user
// must write it only while the block is idle, as the block itself does
// not enforce this.
// Reset empties the table at once (valid bits in flip-flops), sets the
// capacity to 10, and needs no clearing pass.
// A finished result waits in the output register while the receiver
// stalls; the next item is taken once that result is taken.
module bounded_keyed_priority_table_core #(
    parameter int MAX_ENTRIES = bkpt_pkg::MAX_ENTRIES_DEF,
    parameter int ID_BITS     = bkpt_pkg::ID_BITS_DEF,
    parameter int PRIO_BITS   = bkpt_pkg::PRIO_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bkpt_pkg::CAP_BITS-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic [ID_BITS-1:0]            i_file_id,
    input  logic [PRIO_BITS-1:0]          i_priority_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic                          o_out_valid,
    output logic                          o_evicted,
    output logic [ID_BITS-1:0]            o_out_id,
    output logic [PRIO_BITS-1:0]          o_out_priority,
    output logic [bkpt_pkg::CNT_BITS-1:0] o_entry_count
);
    import bkpt_pkg::*;

    localparam int IDX_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SC_BITS  = IDX_BITS + 1;
    localparam int CB       = IDX_BITS + 1;
    localparam logic [SC_BITS-1:0] LAST = SC_BITS'(MAX_ENTRIES - 1);

    // entry memory: id, priority, age rank
    logic [ID_BITS-1:0]   m_id   [MAX_ENTRIES];
    logic [PRIO_BITS-1:0] m_prio [MAX_ENTRIES];
    logic [IDX_BITS-1:0]  m_rank [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_vld;

    t_state               r_state, n_state;
    logic                 r_pass2, n_pass2;   // update pass after scan
    logic [SC_BITS-1:0]   r_addr, n_addr;      // issue address
    logic                 r_rd_en;
    logic [IDX_BITS-1:0]  r_rd_slot;
    logic [ID_BITS-1:0]   r_rd_id;
    logic [PRIO_BITS-1:0] r_rd_prio;
    logic [IDX_BITS-1:0]  r_rd_rank;
    logic                 rd_en;
    logic [IDX_BITS-1:0]  rd_slot;

    logic [CAP_BITS-1:0]  r_cap;
    logic [CB-1:0]        r_count, n_count;
    t_mode                r_mode;
    logic [ID_BITS-1:0]   r_key;
    logic [PRIO_BITS-1:0] r_prio;

    // update pass controls
    logic                 r_drop, n_drop;      // remove slot r_drop_idx
    logic [IDX_BITS-1:0]  r_drop_idx, n_drop_idx;
    logic [IDX_BITS-1:0]  r_drop_rank, n_drop_rank;
    logic                 r_ins, n_ins;
    logic [IDX_BITS-1:0]  r_ins_idx, n_ins_idx;

    logic                 r_ovalid_q;
    logic [1:0]           r_status, n_status;
    logic                 r_oval, n_oval;
    logic                 r_evict, n_evict;
    logic [ID_BITS-1:0]   r_oid, n_oid;
    logic [PRIO_BITS-1:0] r_oprio, n_oprio;

    logic                 top_found, key_found, free_found;
    logic [IDX_BITS-1:0]  top_idx, key_idx, free_idx;
    logic [ID_BITS-1:0]   top_id;
    logic [PRIO_BITS-1:0] top_prio;
    logic [IDX_BITS-1:0]  top_rank, key_rank;
    logic                 scan_start;
    logic [CB-1:0]        eff_cap;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_idx;
    logic [ID_BITS-1:0]   wr_id;
    logic [PRIO_BITS-1:0] wr_prio;
    logic [IDX_BITS-1:0]  wr_rank;
    logic                 wr_id_en, wr_prio_en;
    logic                 accept;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid_q;

    // clamp capacity to 1..MAX_ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CB'(1);
        end else if ({{CB{1'b0}}, r_cap} > (CB + CAP_BITS)'(MAX_ENTRIES)) begin
            eff_cap = CB'(MAX_ENTRIES);
        end else begin
            eff_cap = CB'(r_cap);
        end
    end

    assign rd_en   = (r_state == S_SCAN) && (r_addr <= LAST);
    assign rd_slot = r_addr[IDX_BITS-1:0];

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_id   <= m_id[rd_slot];
        r_rd_prio <= m_prio[rd_slot];
        r_rd_rank <= m_rank[rd_slot];
        r_rd_slot <= rd_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= rd_en;
        end
    end

    assign scan_start = accept;

    bkpt_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS),
        .PRIO_BITS   (PRIO_BITS),
        .IDX_BITS    (IDX_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (scan_start),
        .i_key        (r_key),
        .i_rd_en      (r_rd_en && !r_pass2),
        .i_slot       (r_rd_slot),
        .i_valid      (r_vld[r_rd_slot]),
        .i_id         (r_rd_id),
        .i_prio       (r_rd_prio),
        .i_rank       (r_rd_rank),
        .o_top_found  (top_found),
        .o_top_idx    (top_idx),
        .o_top_id     (top_id),
        .o_top_prio   (top_prio),
        .o_top_rank   (top_rank),
        .o_key_found  (key_found),
        .o_key_idx    (key_idx),
        .o_key_rank   (key_rank),
        .o_free_found (free_found),
        .o_free_idx   (free_idx)
    );

    // Sequencer: scan pass, decide, update pass, final write
    always_comb begin
        n_state     = r_state;
        n_pass2     = r_pass2;
        n_addr      = r_addr;
        n_count     = r_count;
        n_drop      = r_drop;
        n_drop_idx  = r_drop_idx;
        n_drop_rank = r_drop_rank;
        n_ins       = r_ins;
        n_ins_idx   = r_ins_idx;
        n_status    = r_status;
        n_oval      = r_oval;
        n_evict     = r_evict;
        n_oid       = r_oid;
        n_oprio     = r_oprio;
        wr_en       = 1'b0;
        wr_idx      = r_rd_slot;
        wr_id       = r_key;
        wr_prio     = r_prio;
        wr_rank     = r_rd_rank;
        wr_id_en    = 1'b0;
        wr_prio_en  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state  = S_SCAN;
                    n_pass2  = 1'b0;
                    n_addr   = '0;
                    n_status = ST_OK;
                    n_oval   = 1'b0;
                    n_evict  = 1'b0;
                    n_oid    = '0;
                    n_oprio  = '0;
                    n_drop   = 1'b0;
                    n_ins    = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_addr <= LAST) begin
                    n_addr = r_addr + 1'b1;
                end
                // rank rewrite during the update pass
                if (r_pass2 && r_rd_en && r_drop && r_vld[r_rd_slot] &&
                    r_rd_slot != r_drop_idx && r_rd_rank > r_drop_rank) begin
                    wr_en   = 1'b1;
                    wr_rank = r_rd_rank - 1'b1;
                end
                if (!rd_en && !r_rd_en) begin
                    n_state = r_pass2 ? S_INSERT : S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_SCAN;
                n_pass2 = 1'b1;
                n_addr  = '0;
                case (r_mode)
                    MODE_PUSH: begin
                        if (key_found) begin
                            n_status = ST_DUPLICATE;
                            n_state  = S_DONE;
                        end else begin
                            n_ins = 1'b1;
                            if (r_count >= eff_cap && top_found) begin
                                n_oval      = 1'b1;
                                n_evict     = 1'b1;
                                n_oid       = top_id;
                                n_oprio     = top_prio;
                                n_drop      = 1'b1;
                                n_drop_idx  = top_idx;
                                n_drop_rank = top_rank;
                                n_count     = r_count - 1'b1;
                                n_ins_idx   = top_idx;
                            end else begin
                                n_ins_idx = free_idx;
                                n_ins     = free_found;
                            end
                        end
                    end
                    MODE_POP, MODE_TOP: begin
                        if (!top_found) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_oval  = 1'b1;
                            n_oid   = top_id;
                            n_oprio = top_prio;
                            if (r_mode == MODE_POP) begin
                                n_drop      = 1'b1;
                                n_drop_idx  = top_idx;
                                n_drop_rank = top_rank;
                                n_count     = r_count - 1'b1;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                    end
                    MODE_MODIFY: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else if (!key_found) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_drop      = 1'b1;
                            n_drop_idx  = key_idx;
                            n_drop_rank = key_rank;
                            n_ins       = 1'b1;
                            n_ins_idx   = key_idx;
                            n_count     = r_count - 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INSERT: begin
                if (r_ins) begin
                    wr_en      = 1'b1;
                    wr_idx     = r_ins_idx;
                    wr_rank    = r_count[IDX_BITS-1:0];
                    wr_prio_en = 1'b1;
                    wr_id_en   = (r_mode == MODE_PUSH);
                    n_count    = r_count + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_rank[wr_idx] <= wr_rank;
            if (wr_prio_en) begin
                m_prio[wr_idx] <= wr_prio;
            end
            if (wr_id_en) begin
                m_id[wr_idx] <= wr_id;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pass2    <= 1'b0;
            r_addr     <= '0;
            r_count    <= '0;
            r_vld      <= '0;
            r_cap      <= CAPACITY_RESET;
            r_ovalid_q <= 1'b0;
            r_drop     <= 1'b0;
            r_ins      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass2 <= n_pass2;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_ins   <= n_ins;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            // drop the removed slot once the update pass ends
            if (r_state == S_SCAN && n_state == S_INSERT && r_drop) begin
                r_vld[r_drop_idx] <= 1'b0;
            end
            if (r_state == S_INSERT && r_ins) begin
                r_vld[r_ins_idx] <= 1'b1;
            end
            if (r_state == S_DONE) begin
                r_ovalid_q <= 1'b1;
            end else if (r_ovalid_q && i_ready) begin
                r_ovalid_q <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= i_file_id;
            r_prio <= i_priority_req;
        end
        r_drop_idx  <= n_drop_idx;
        r_drop_rank <= n_drop_rank;
        r_ins_idx   <= n_ins_idx;
        r_status    <= n_status;
        r_oval      <= n_oval;
        r_evict     <= n_evict;
        r_oid       <= n_oid;
        r_oprio     <= n_oprio;
    end

    assign o_valid        = r_ovalid_q;
    assign o_status       = r_status;
    assign o_out_valid    = r_oval;
    assign o_evicted      = r_evict;
    assign o_out_id       = r_oid;
    assign o_out_priority = r_oprio;
    assign o_entry_count  = CNT_BITS'(r_count);

    // count never exceeds the number of slots
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(MAX_ENTRIES))
        else $error("entry count out of range");

    // no new item while a result waits
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("accept while result pending");

    // an eviction always reports an entry
    a_evict_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted) |-> (o_out_valid && o_status == ST_OK))
        else $error("eviction without entry");

    // count matches valid bits when idle
    a_count_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_vld) == int'(r_count)))
        else $error("count and valid bits disagree");

endmodule
